>>> hw/rtl/sle_pkg.sv
`default_nettype none

package sle_pkg;

	// request word
	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  position;
		logic [31:0] value;
	} req_t;

	// response word
	typedef struct packed {
		logic [2:0] status;
		logic [3:0] found_index;
		logic [4:0] count;
	} rsp_t;

	// operation codes
	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_FIND       = 3'd4,
		OP_INSERT     = 3'd5,
		OP_ERASE      = 3'd6
	} op_t;

	// status codes
	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_EMPTY     = 3'd2,
		STAT_BADPOS    = 3'd3,
		STAT_NOTFOUND  = 3'd4
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE     = 3'd0,
		S_SHIFT_UP = 3'd1,
		S_SHIFT_DN = 3'd2,
		S_FIND     = 3'd3,
		S_PUT      = 3'd4,
		S_RESULT   = 3'd5
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/sle_ram.sv
`default_nettype none

module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/sequential_list_engine.sv
`default_nettype none

// channel | direction | handshake            | word
// req     | in        | req_valid/req_stall  | mode, position, value
// rsp     | out       | rsp_valid/rsp_stall  | status, found_index, count
//
// one word in flight; push back, pop back, refusals, the removal of the last entry,
// a find on an empty list and the unused code go straight to the registered result;
// push front and insert shift entries up, pop front and erase shift them down, one
// entry at a time through the single ram read port; a find sweeps up from index 0
// to the first hit or the last entry; arst_n clears count, sequencer, sweep flags
// and output valid only; a stalled response holds while the next runs

module sequential_list_engine #(
	parameter int LIST_DEPTH = 16,
	parameter int WORD_BITS  = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire sle_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output sle_pkg::rsp_t      rsp
);

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);

	sle_pkg::state_t  state_q, state_d;
	sle_pkg::status_t status_q, status_d;

	logic [CW-1:0]        count_q, count_d;
	logic [AW-1:0]        pos_q, pos_d;
	logic [WORD_BITS-1:0] val_q, val_d;
	logic [AW-1:0]        rp_q, rp_d;      // read pointer of the sweep
	logic                 more_q, more_d;  // reads still to issue
	logic [3:0]           found_q, found_d;
	sle_pkg::rsp_t        rsp_q, rsp_d;
	logic                 rsp_valid_q, rsp_valid_d;

	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_idx_s1;

	// memory port signals
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [WORD_BITS-1:0] mem_rdata;

	// helpers
	logic                 accept;
	logic [WORD_BITS+31:0] val_wide;
	logic [WORD_BITS-1:0] val_in;
	logic [CW+3:0]        pos_w, count_w;
	logic [AW-1:0]        pos_a;
	logic [CW-1:0]        cnt_m1;
	logic [AW-1:0]        last_a;
	logic                 full, empty, pos_ok, pos_inner;
	logic [CW+4:0]        count_x;
	logic [AW+3:0]        idx_x;

	assign accept    = req_valid && (state_q == sle_pkg::S_IDLE);
	assign req_stall = (state_q != sle_pkg::S_IDLE);

	// value kept to the word width
	assign val_wide  = {WORD_BITS'(0), req.value};
	assign val_in    = val_wide[WORD_BITS-1:0];

	// position compared at full width before it is narrowed to an address
	assign pos_w     = {CW'(0), req.position};
	assign count_w   = {4'b0, count_q};
	assign pos_a     = pos_w[AW-1:0];
	assign pos_ok    = (pos_w < count_w);
	assign pos_inner = ((pos_w + (CW + 4)'(1)) < count_w);

	assign cnt_m1    = count_q - CW'(1);
	assign last_a    = cnt_m1[AW-1:0];
	assign full      = (count_q == CW'(LIST_DEPTH));
	assign empty     = (count_q == '0);

	assign count_x   = {5'b0, count_q};
	assign idx_x     = {4'b0, rd_idx_s1};

	assign mem_re    = more_q && ((state_q == sle_pkg::S_SHIFT_UP) ||
		(state_q == sle_pkg::S_SHIFT_DN) || (state_q == sle_pkg::S_FIND));

	sle_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (LIST_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rp_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sle_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		status_d    = status_q;
		count_d     = count_q;
		pos_d       = pos_q;
		val_d       = val_q;
		rp_d        = rp_q;
		more_d      = more_q;
		found_d     = found_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q;
		mem_we      = 1'b0;
		mem_waddr   = pos_q;
		mem_wdata   = val_q;

		// output slot drains independently
		if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end

		case (state_q)
			sle_pkg::S_IDLE: begin
				if (accept) begin
					status_d = sle_pkg::STAT_OK;
					found_d  = '0;
					val_d    = val_in;
					state_d  = sle_pkg::S_RESULT;
					case (sle_pkg::op_t'(req.mode))
						sle_pkg::OP_PUSH_BACK: begin
							if (full) begin
								status_d = sle_pkg::STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = val_in;
								count_d   = count_q + CW'(1);
							end
						end
						sle_pkg::OP_PUSH_FRONT: begin
							if (full) begin
								status_d = sle_pkg::STAT_FULL;
							end else begin
								pos_d = '0;
								if (empty) begin
									state_d = sle_pkg::S_PUT;
								end else begin
									rp_d    = last_a;
									more_d  = 1'b1;
									state_d = sle_pkg::S_SHIFT_UP;
								end
							end
						end
						sle_pkg::OP_POP_BACK: begin
							if (empty) begin
								status_d = sle_pkg::STAT_EMPTY;
							end else begin
								count_d = cnt_m1;
							end
						end
						sle_pkg::OP_POP_FRONT: begin
							if (empty) begin
								status_d = sle_pkg::STAT_EMPTY;
							end else if (count_q > CW'(1)) begin
								rp_d    = AW'(1);
								more_d  = 1'b1;
								state_d = sle_pkg::S_SHIFT_DN;
							end else begin
								count_d = cnt_m1;
							end
						end
						sle_pkg::OP_FIND: begin
							if (empty) begin
								status_d = sle_pkg::STAT_NOTFOUND;
							end else begin
								rp_d    = '0;
								more_d  = 1'b1;
								state_d = sle_pkg::S_FIND;
							end
						end
						sle_pkg::OP_INSERT: begin
							if (!pos_ok) begin
								status_d = sle_pkg::STAT_BADPOS;
							end else if (full) begin
								status_d = sle_pkg::STAT_FULL;
							end else begin
								pos_d   = pos_a;
								rp_d    = last_a;
								more_d  = 1'b1;
								state_d = sle_pkg::S_SHIFT_UP;
							end
						end
						sle_pkg::OP_ERASE: begin
							if (!pos_ok) begin
								status_d = sle_pkg::STAT_BADPOS;
							end else if (pos_inner) begin
								rp_d    = pos_a + AW'(1);
								more_d  = 1'b1;
								state_d = sle_pkg::S_SHIFT_DN;
							end else begin
								count_d = cnt_m1;
							end
						end
						default: begin
							// unused code: no change
						end
					endcase
				end
			end
			sle_pkg::S_SHIFT_UP: begin
				// read i-1, write i in the next cycle, walking down to pos
				if (more_q) begin
					if (rp_q == pos_q) begin
						more_d = 1'b0;
					end else begin
						rp_d = rp_q - AW'(1);
					end
				end
				if (rd_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 + AW'(1);
					mem_wdata = mem_rdata;
				end
				if (!more_q && !rd_vld_s1) begin
					state_d = sle_pkg::S_PUT;
				end
			end
			sle_pkg::S_SHIFT_DN: begin
				// read i+1, write i in the next cycle, walking up to the last entry
				if (more_q) begin
					if (rp_q == last_a) begin
						more_d = 1'b0;
					end else begin
						rp_d = rp_q + AW'(1);
					end
				end
				if (rd_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 - AW'(1);
					mem_wdata = mem_rdata;
				end
				if (!more_q && !rd_vld_s1) begin
					count_d = cnt_m1;
					state_d = sle_pkg::S_RESULT;
				end
			end
			sle_pkg::S_FIND: begin
				if (more_q) begin
					if (rp_q == last_a) begin
						more_d = 1'b0;
					end else begin
						rp_d = rp_q + AW'(1);
					end
				end
				if (rd_vld_s1 && (mem_rdata == val_q)) begin
					// first hit wins, stop the sweep
					more_d   = 1'b0;
					found_d  = idx_x[3:0];
					status_d = sle_pkg::STAT_OK;
					state_d  = sle_pkg::S_RESULT;
				end else if (!more_q && !rd_vld_s1) begin
					status_d = sle_pkg::STAT_NOTFOUND;
					state_d  = sle_pkg::S_RESULT;
				end
			end
			sle_pkg::S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = val_q;
				count_d   = count_q + CW'(1);
				state_d   = sle_pkg::S_RESULT;
			end
			sle_pkg::S_RESULT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_d.status      = status_q;
					rsp_d.found_index = found_q;
					rsp_d.count       = count_x[4:0];
					rsp_valid_d       = 1'b1;
					state_d           = sle_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sle_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			more_q      <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			more_q      <= more_d;
			rd_vld_s1   <= mem_re;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		status_q  <= status_d;
		pos_q     <= pos_d;
		val_q     <= val_d;
		rp_q      <= rp_d;
		found_q   <= found_d;
		rd_idx_s1 <= rp_q;
		rsp_q     <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> verif/list_checker.sv
`timescale 1ns / 1ps

module list_checker
	import sle_pkg::*;
#(
	parameter int LIST_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   errors,
	output int   pending
);

	logic [31:0] list_words [0:LIST_DEPTH-1];
	int          list_len;
	rsp_t        awaited_rsp [$];
	rsp_t        oldest;
	int          mismatch_count = 0;
	int          waiting = 0;

	assign errors  = mismatch_count;
	assign pending = waiting;

	// applies one request word to the shadow list and returns its response
	function automatic rsp_t apply_list_op(input req_t w);
		rsp_t       r;
		logic [2:0] st;
		logic [3:0] hit;
		logic       seen;
		int         i;
		int         p;
		st   = STAT_OK;
		hit  = '0;
		seen = 1'b0;
		p    = int'(w.position);
		case (w.mode)
			OP_PUSH_BACK: begin
				if (list_len >= LIST_DEPTH) begin
					st = STAT_FULL;
				end else begin
					list_words[list_len] = w.value;
					list_len++;
				end
			end
			OP_PUSH_FRONT: begin
				if (list_len >= LIST_DEPTH) begin
					st = STAT_FULL;
				end else begin
					for (i = list_len; i > 0; i--)
						list_words[i] = list_words[i-1];
					list_words[0] = w.value;
					list_len++;
				end
			end
			OP_POP_BACK: begin
				if (list_len == 0)
					st = STAT_EMPTY;
				else
					list_len--;
			end
			OP_POP_FRONT: begin
				if (list_len == 0) begin
					st = STAT_EMPTY;
				end else begin
					for (i = 0; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			OP_FIND: begin
				st = STAT_NOTFOUND;
				for (i = 0; i < list_len; i++) begin
					if (!seen && list_words[i] == w.value) begin
						seen = 1'b1;
						st   = STAT_OK;
						hit  = i[3:0];
					end
				end
			end
			OP_INSERT: begin
				if (p >= list_len) begin
					st = STAT_BADPOS;
				end else if (list_len >= LIST_DEPTH) begin
					st = STAT_FULL;
				end else begin
					for (i = list_len; i > p; i--)
						list_words[i] = list_words[i-1];
					list_words[p] = w.value;
					list_len++;
				end
			end
			OP_ERASE: begin
				if (p >= list_len) begin
					st = STAT_BADPOS;
				end else begin
					for (i = p; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			default: ;
		endcase
		r.status      = st;
		r.found_index = hit;
		r.count       = list_len[4:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [4:0] want, input logic [4:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// response is checked before the request of the same edge is queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			awaited_rsp.delete();
			waiting = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t ns: response with none awaited, actual status %0d index %0d count %0d",
						$time, rsp.status, rsp.found_index, rsp.count);
					mismatch_count++;
				end else begin
					oldest = awaited_rsp.pop_front();
					check_field("status", 5'(oldest.status), 5'(rsp.status));
					check_field("found_index", 5'(oldest.found_index), 5'(rsp.found_index));
					check_field("count", oldest.count, rsp.count);
				end
			end
			if (req_valid && !req_stall)
				awaited_rsp.push_back(apply_list_op(req));
			waiting = awaited_rsp.size();
		end
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import sle_pkg::*;

	localparam int          LIST_DEPTH     = 16;
	localparam int          BLOCKS         = 31;
	localparam int          BLOCK_WORDS    = 50;
	localparam int          LONG_HOLD      = 300;
	localparam int          TAIL_CYCLES    = LIST_DEPTH + 8;
	localparam int          WATCHDOG_LIMIT = 3000;
	localparam logic [2:0]  OP_UNUSED      = 3'd7;

	// traffic mixes for the random part
	localparam int PH_GROW   = 0;
	localparam int PH_SHRINK = 1;
	localparam int PH_MIXED  = 2;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int chk_errors;
	int chk_pending;

	// flags and counters of the sender, receiver and watchdog processes
	logic        no_gaps = 1'b0;
	int          hold_requests = 0;
	int          hold_served = 0;
	int          idle_cycles = 0;
	logic [31:0] value_pool [0:7];

	sequential_list_engine #(
		.LIST_DEPTH(LIST_DEPTH),
		.WORD_BITS (32)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	list_checker #(
		.LIST_DEPTH(LIST_DEPTH)
	) checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.errors   (chk_errors),
		.pending  (chk_pending)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic req_t make_word(input logic [2:0] m, input logic [3:0] p,
			input logic [31:0] v);
		req_t w;
		w.mode     = m;
		w.position = p;
		w.value    = v;
		return w;
	endfunction

	// random request word; the phase tilts the mix towards growing or shrinking
	// the list so that it spends time both near empty and near full
	function automatic req_t random_word(input int phase, input int pos_hi);
		int          r;
		logic [2:0]  m;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		case (phase)
			PH_GROW: begin
				m = (r < 30) ? OP_PUSH_BACK : (r < 55) ? OP_PUSH_FRONT :
					(r < 80) ? OP_INSERT : (r < 90) ? OP_FIND :
					(r < 95) ? OP_POP_BACK : OP_ERASE;
			end
			PH_SHRINK: begin
				m = (r < 25) ? OP_POP_BACK : (r < 50) ? OP_POP_FRONT :
					(r < 80) ? OP_ERASE : (r < 90) ? OP_FIND :
					(r < 95) ? OP_PUSH_BACK : OP_INSERT;
			end
			default: begin
				m = (r < 14) ? OP_PUSH_BACK : (r < 28) ? OP_PUSH_FRONT :
					(r < 42) ? OP_POP_BACK : (r < 56) ? OP_POP_FRONT :
					(r < 70) ? OP_FIND : (r < 84) ? OP_INSERT :
					(r < 98) ? OP_ERASE : OP_UNUSED;
			end
		endcase
		// mostly pooled values so that finds hit and duplicates appear
		if ($urandom_range(0, 9) < 7)
			v = value_pool[$urandom_range(0, 7)];
		else
			v = $urandom;
		return make_word(m, 4'($urandom_range(0, pos_hi)), v);
	endfunction

	// offers one word after a random gap and holds it until it is taken
	task automatic send_word(input req_t w);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// sender goes quiet until every awaited response has come back
	task automatic drain_results;
		req_valid <= 1'b0;
		@(posedge clk);
		wait (chk_pending == 0);
		@(posedge clk);
	endtask

	// receiver: a random hold-off before each word, or one long hold when asked
	initial begin
		int n;
		forever begin
			if (hold_requests != hold_served) begin
				hold_served++;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				n = no_gaps ? 0 : $urandom_range(0, 5);
				if (n > 0) begin
					rsp_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// watchdog: too long without any word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int i;
		int blk;
		int phase;
		int pos_hi;
		req_valid <= 1'b0;
		req       <= '0;
		arst_n    <= 1'b0;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		for (i = 2; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: pops report empty, find misses, any position is bad
		send_word(make_word(OP_POP_BACK, 4'd0, 32'h0));
		send_word(make_word(OP_POP_FRONT, 4'd0, 32'h0));
		send_word(make_word(OP_FIND, 4'd0, 32'h0));
		send_word(make_word(OP_INSERT, 4'd0, 32'h1234_5678));
		send_word(make_word(OP_ERASE, 4'd15, 32'h0));
		// unused mode leaves the list alone
		send_word(make_word(OP_UNUSED, 4'd15, 32'hFFFF_FFFF));

		// small list built from both ends and the middle
		send_word(make_word(OP_PUSH_BACK, 4'd0, 32'hFFFF_FFFF));
		send_word(make_word(OP_PUSH_FRONT, 4'd0, 32'h0000_0000));
		send_word(make_word(OP_INSERT, 4'd0, 32'hA5A5_A5A5));
		send_word(make_word(OP_INSERT, 4'd2, 32'h5A5A_5A5A));
		send_word(make_word(OP_FIND, 4'd0, 32'hFFFF_FFFF));
		send_word(make_word(OP_FIND, 4'd0, 32'hDEAD_0001));
		// position equal to count is refused, then erase of the last entry
		send_word(make_word(OP_INSERT, 4'd4, 32'h0));
		send_word(make_word(OP_ERASE, 4'd4, 32'h0));
		send_word(make_word(OP_ERASE, 4'd3, 32'h0));

		// fill up, then every growing request is refused as full
		for (i = 0; i < 13; i++)
			send_word(make_word(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, 4'd0, $urandom));
		send_word(make_word(OP_PUSH_BACK, 4'd0, 32'h1));
		send_word(make_word(OP_PUSH_FRONT, 4'd0, 32'h2));
		send_word(make_word(OP_INSERT, 4'd15, 32'h3));
		send_word(make_word(OP_ERASE, 4'd15, 32'h0));
		send_word(make_word(OP_ERASE, 4'd0, 32'h0));
		send_word(make_word(OP_POP_FRONT, 4'd0, 32'h0));
		drain_results();

		// random part in blocks, each with its own mix, position spread and pacing
		for (blk = 0; blk < BLOCKS; blk++) begin
			phase   = $urandom_range(0, 2);
			pos_hi  = (blk % 3 == 0) ? 15 : (blk % 3 == 1) ? 7 : 3;
			no_gaps = ($urandom_range(0, 3) == 0);
			// long receiver hold-off while the sender keeps offering
			if (blk == 4 || blk == 19)
				hold_requests++;
			for (i = 0; i < BLOCK_WORDS; i++)
				send_word(random_word(phase, pos_hi));
			if (blk % 8 == 7)
				drain_results();
		end
		no_gaps = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (chk_errors == 0 && chk_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
